FILE: hw/rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// shared types for the trial division primality tester: controller states
// and the command and status groups between controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_BOUND,
        ST_DIVIDE,
        ST_TEST,
        ST_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_value;   // capture input word
        logic init_trial;   // divisor 3, square 9
        logic start_div;    // clear remainder, bit index to msb
        logic div_step;     // one restoring remainder step
        logic next_trial;   // divisor += 2, square updated
        logic set_verdict;  // store verdict bit
        logic verdict;      // verdict value when set_verdict
        logic out_load;     // move verdict into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic le_one;       // value is 0 or 1
        logic is_two;       // value is 2
        logic is_even;      // value lsb clear
        logic sq_gt;        // divisor squared exceeds value
        logic last_bit;     // remainder step on bit 0
        logic rem_zero;     // remainder is zero
        logic out_free;     // output register can take a word this cycle
    } t_status;

endpackage

`default_nettype wire

FILE: hw/rtl/ptd_datapath.sv
// ----------------------------------------------------------------------------
// ptd_datapath
// value, divisor, divisor square, bit-serial remainder and output register
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  ptd_pkg::t_cmd           i_cmd,
    input  wire [VALUE_WIDTH-1:0]   i_value,
    input  wire                     i_out_stall,
    output ptd_pkg::t_status        o_status,
    output logic                    o_out_valid,
    output logic                    o_is_prime
);

    localparam int IDX_W = $clog2(VALUE_WIDTH);
    localparam int SQ_W  = VALUE_WIDTH + 2;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [SQ_W-1:0]        r_sq;
    logic [VALUE_WIDTH:0]   r_rem;
    logic [IDX_W-1:0]       r_bit;
    logic                   r_verdict;
    logic                   r_out_valid;
    logic                   r_out_prime;

    logic [VALUE_WIDTH:0]   n_shift;
    logic [VALUE_WIDTH:0]   n_rem;
    logic [SQ_W-1:0]        n_sq;

    // restoring remainder step
    always_comb begin
        n_shift = {r_rem[VALUE_WIDTH-1:0], r_value[r_bit]};
        if (n_shift >= {1'b0, r_div}) begin
            n_rem = n_shift - {1'b0, r_div};
        end else begin
            n_rem = n_shift;
        end
    end

    // (d+2)^2 = d^2 + 4d + 4
    assign n_sq = r_sq + {r_div, 2'b00} + SQ_W'(4);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_value) begin
            r_value <= i_value;
        end
        if (i_cmd.init_trial) begin
            r_div <= VALUE_WIDTH'(3);
            r_sq  <= SQ_W'(9);
        end else if (i_cmd.next_trial) begin
            r_div <= r_div + VALUE_WIDTH'(2);
            r_sq  <= n_sq;
        end
        if (i_cmd.start_div) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
        end
        if (i_cmd.set_verdict) begin
            r_verdict <= i_cmd.verdict;
        end
        if (i_cmd.out_load) begin
            r_out_prime <= r_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_div) begin
                r_bit <= IDX_W'(VALUE_WIDTH - 1);
            end else if (i_cmd.div_step) begin
                r_bit <= r_bit - IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.le_one   = (r_value <= VALUE_WIDTH'(1));
        o_status.is_two   = (r_value == VALUE_WIDTH'(2));
        o_status.is_even  = ~r_value[0];
        o_status.sq_gt    = (r_sq > {2'b00, r_value});
        o_status.last_bit = (r_bit == '0);
        o_status.rem_zero = (r_rem == '0);
        o_status.out_free = ~r_out_valid | ~i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_out_prime;

endmodule

`default_nettype wire

FILE: hw/rtl/ptd_ctrl.sv
// ----------------------------------------------------------------------------
// ptd_ctrl
// sequencer: special cases, bound check, remainder loop, result handoff
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  ptd_pkg::t_status  i_status,
    output ptd_pkg::t_cmd     o_cmd,
    output logic              o_busy
);

    ptd_pkg::t_state r_state;
    ptd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptd_pkg::ST_IDLE: begin
                if (i_valid) n_state = ptd_pkg::ST_CLASSIFY;
            end
            ptd_pkg::ST_CLASSIFY: begin
                if (i_status.le_one || i_status.is_two || i_status.is_even) begin
                    n_state = ptd_pkg::ST_FINISH;
                end else begin
                    n_state = ptd_pkg::ST_BOUND;
                end
            end
            ptd_pkg::ST_BOUND: begin
                if (i_status.sq_gt) n_state = ptd_pkg::ST_FINISH;
                else                n_state = ptd_pkg::ST_DIVIDE;
            end
            ptd_pkg::ST_DIVIDE: begin
                if (i_status.last_bit) n_state = ptd_pkg::ST_TEST;
            end
            ptd_pkg::ST_TEST: begin
                if (i_status.rem_zero) n_state = ptd_pkg::ST_FINISH;
                else                   n_state = ptd_pkg::ST_BOUND;
            end
            ptd_pkg::ST_FINISH: begin
                if (i_status.out_free) n_state = ptd_pkg::ST_IDLE;
            end
            default: n_state = ptd_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            ptd_pkg::ST_IDLE: begin
                o_busy           = 1'b0;
                o_cmd.load_value = i_valid;
            end
            ptd_pkg::ST_CLASSIFY: begin
                o_cmd.init_trial  = 1'b1;
                o_cmd.set_verdict = 1'b1;
                o_cmd.verdict     = i_status.is_two;
            end
            ptd_pkg::ST_BOUND: begin
                o_cmd.start_div   = ~i_status.sq_gt;
                o_cmd.set_verdict = i_status.sq_gt;
                o_cmd.verdict     = 1'b1;
            end
            ptd_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            ptd_pkg::ST_TEST: begin
                o_cmd.next_trial  = ~i_status.rem_zero;
                o_cmd.set_verdict = i_status.rem_zero;
                o_cmd.verdict     = 1'b0;
            end
            ptd_pkg::ST_FINISH: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: o_busy = 1'b1;
        endcase
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("output register loaded while occupied");

    a_accept_to_classify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptd_pkg::ST_IDLE && i_valid) |=> (r_state == ptd_pkg::ST_CLASSIFY))
        else $error("accepted word not classified");

    a_divide_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptd_pkg::ST_DIVIDE && i_status.last_bit) |=>
        (r_state == ptd_pkg::ST_TEST))
        else $error("remainder loop did not end on last bit");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptd_pkg::ST_FINISH && !i_status.out_free) |=>
        (r_state == ptd_pkg::ST_FINISH))
        else $error("verdict dropped while output stalled");

endmodule

`default_nettype wire

FILE: hw/rtl/prime_test_trial_division.sv
// ----------------------------------------------------------------------------
// prime_test_trial_division
// primality test by trial division over odd divisors, one word in, one
// verdict word out
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  -----------------------------
//  input    in         i_valid / o_stall    i_value [VALUE_WIDTH-1:0]
//  output   out        o_valid / i_stall    o_is_prime
//
//  0, 1, 2 and even values go from classify straight to finish; an odd value
//  runs, per divisor tried, a bound check, the bit-serial remainder loop over
//  all W = VALUE_WIDTH bits and a zero test (a 32-bit prime near 2^32 tries
//  about 2^15 divisors)
//  one word in flight; the next is taken once the verdict is registered
//  reset clears controller state and output valid; o_stall is high away from idle
//
`default_nettype none

module prime_test_trial_division #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // input channel
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire [VALUE_WIDTH-1:0]   i_value,
    // output channel
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic                    o_is_prime
);

    ptd_pkg::t_cmd    w_cmd;
    ptd_pkg::t_status w_status;
    logic             w_busy;

    // sequencer: walks special cases, divisor bound and remainder loop
    ptd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy)
    );

    // datapath: value, divisor, running square, remainder, output register
    ptd_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_value),
        .i_out_stall (i_stall),
        .o_status    (w_status),
        .o_out_valid (o_valid),
        .o_is_prime  (o_is_prime)
    );

    // input side is held off while a word is being tested
    assign o_stall = w_busy;

endmodule

`default_nettype wire
